[src/assert_macros.svh]
// Assertion helpers for the RTL; they compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: %m");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: %m");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[src/tzr_pkg.sv]
package tzr_pkg;

	localparam int CELLS      = 1760;
	localparam int ADDR_W     = 11;
	localparam int RING_STEPS = 324;
	localparam int TUBE_STEPS = 90;
	localparam int I_W        = 9;
	localparam int J_W        = 7;
	localparam int NORM_CONST = 3145728;
	localparam int DIV_STEPS  = 9;

	localparam logic signed [31:0] VIEW_DIST = 32'sd5242880;
	localparam logic [6:0] SPACE_CHAR = 7'd32;
	localparam logic signed [7:0] FAR_DEPTH = 8'sd127;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;

	// Datapath operations
	localparam logic [3:0] DP_NOP     = 4'd0;
	localparam logic [3:0] DP_START   = 4'd1;
	localparam logic [3:0] DP_CLR     = 4'd2;
	localparam logic [3:0] DP_JPRE    = 4'd3;
	localparam logic [3:0] DP_P1      = 4'd4;
	localparam logic [3:0] DP_P2      = 4'd5;
	localparam logic [3:0] DP_P3      = 4'd6;
	localparam logic [3:0] DP_P4      = 4'd7;
	localparam logic [3:0] DP_ADDR    = 4'd8;
	localparam logic [3:0] DP_WR      = 4'd9;
	localparam logic [3:0] DP_RD      = 4'd10;
	localparam logic [3:0] DP_OUT_RD  = 4'd11;
	localparam logic [3:0] DP_OUT_FRM = 4'd12;

	// Rotation unit phases and targets
	localparam logic [1:0] ADV_NONE  = 2'd0;
	localparam logic [1:0] ADV_ROT   = 2'd1;
	localparam logic [1:0] ADV_NORM  = 2'd2;
	localparam logic [1:0] ADV_SCALE = 2'd3;

	localparam logic [1:0] ADV_I = 2'd0;
	localparam logic [1:0] ADV_J = 2'd1;
	localparam logic [1:0] ADV_A = 2'd2;
	localparam logic [1:0] ADV_B = 2'd3;

	typedef struct packed {
		logic [3:0] op;
		logic       div_step;
		logic [1:0] adv_ph;
		logic [1:0] adv_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic i_last;
		logic j_last;
		logic out_free;
	} dp_sts_t;

	function automatic logic [6:0] shade_char(input logic [3:0] n);
		logic [6:0] c;
		case (n)
			4'd0:  c = 7'd46;
			4'd1:  c = 7'd44;
			4'd2:  c = 7'd45;
			4'd3:  c = 7'd126;
			4'd4:  c = 7'd58;
			4'd5:  c = 7'd59;
			4'd6:  c = 7'd61;
			4'd7:  c = 7'd33;
			4'd8:  c = 7'd42;
			4'd9:  c = 7'd35;
			4'd10: c = 7'd36;
			default: c = 7'd64;
		endcase
		return c;
	endfunction

endpackage

[src/tzr_advance.sv]
module tzr_advance (
	input  logic                clk,
	input  logic [1:0]          ph,
	input  logic [1:0]          sel,
	input  logic signed [15:0]  c_in,
	input  logic signed [15:0]  s_in,
	output logic signed [15:0]  c_out,
	output logic signed [15:0]  s_out
);
	import tzr_pkg::*;

	logic signed [19:0] ms, mc, rs, rc;
	logic signed [17:0] c1, s1;
	logic signed [17:0] c1_q, s1_q;
	logic signed [37:0] sq;
	logic signed [23:0] k, k_q;
	logic signed [41:0] pc, ps;
	logic sh7;

	// The tube step uses 9/128, the other three 5/128 or 5/256.
	assign sh7 = (sel == ADV_J) || (sel == ADV_A);
	assign ms = (sel == ADV_J) ? ((20'(s_in) <<< 3) + 20'(s_in)) : ((20'(s_in) <<< 2) + 20'(s_in));
	assign mc = (sel == ADV_J) ? ((20'(c_in) <<< 3) + 20'(c_in)) : ((20'(c_in) <<< 2) + 20'(c_in));
	assign rs = sh7 ? (ms >>> 7) : (ms >>> 8);
	assign rc = sh7 ? (mc >>> 7) : (mc >>> 8);
	assign c1 = 18'(c_in) - 18'(rs);
	assign s1 = 18'(s_in) + 18'(rc);

	assign sq = 38'(c1_q) * 38'(c1_q) + 38'(s1_q) * 38'(s1_q);
	assign k  = 24'((38'(NORM_CONST) - sq) >>> 11);

	assign pc = 42'(c1_q) * 42'(k_q);
	assign ps = 42'(s1_q) * 42'(k_q);
	assign c_out = 16'(pc >>> 10);
	assign s_out = 16'(ps >>> 10);

	always_ff @(posedge clk) begin
		if (ph == ADV_ROT) begin
			c1_q <= c1;
			s1_q <= s1;
		end
		if (ph == ADV_NORM) begin
			k_q <= k;
		end
	end

endmodule

[src/tzr_div.sv]
module tzr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic               step,
	input  logic signed [39:0] num,
	input  logic signed [31:0] den,
	output logic [7:0]         q,
	output logic               neg,
	output logic               ovf,
	output logic               done
);
	import tzr_pkg::*;

	logic [39:0] rem_q, dsh_q;
	logic [7:0]  q_q;
	logic        neg_q, ovf_q;
	logic [3:0]  cnt_q;
	logic        ge;
	logic signed [39:0] num_neg;
	logic signed [31:0] den_neg;

	assign num_neg = -num;
	assign den_neg = -den;
	assign ge = rem_q >= dsh_q;

	// The first step only decides whether the quotient reaches 256.
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= num[39] ? 40'(num_neg) : 40'(num);
			dsh_q <= {(den[31] ? den_neg : den), 8'b0};
			q_q   <= '0;
			neg_q <= num[39] ^ den[31];
		end else if (step) begin
			dsh_q <= dsh_q >> 1;
			if (cnt_q == 4'd0) begin
				ovf_q <= ge;
			end else begin
				q_q <= {q_q[6:0], ge};
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	assign q = q_q;
	assign neg = neg_q;
	assign ovf = ovf_q;
	assign done = cnt_q == 4'(DIV_STEPS);

endmodule

[src/tzr_ctrl.sv]
module tzr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_op,
	output logic             in_ready,
	input  tzr_pkg::dp_sts_t sts,
	output tzr_pkg::dp_cmd_t cmd
);
	import tzr_pkg::*;

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_RDOUT = 5'd2;
	localparam logic [4:0] S_JPRE  = 5'd3;
	localparam logic [4:0] S_P1    = 5'd4;
	localparam logic [4:0] S_P2    = 5'd5;
	localparam logic [4:0] S_P3    = 5'd6;
	localparam logic [4:0] S_P4    = 5'd7;
	localparam logic [4:0] S_A1    = 5'd8;
	localparam logic [4:0] S_A2    = 5'd9;
	localparam logic [4:0] S_A3    = 5'd10;
	localparam logic [4:0] S_DIVW  = 5'd11;
	localparam logic [4:0] S_WR    = 5'd12;
	localparam logic [4:0] S_JA1   = 5'd13;
	localparam logic [4:0] S_JA2   = 5'd14;
	localparam logic [4:0] S_JA3   = 5'd15;
	localparam logic [4:0] S_FA1   = 5'd16;
	localparam logic [4:0] S_FA2   = 5'd17;
	localparam logic [4:0] S_FA3   = 5'd18;
	localparam logic [4:0] S_FB1   = 5'd19;
	localparam logic [4:0] S_FB2   = 5'd20;
	localparam logic [4:0] S_FB3   = 5'd21;
	localparam logic [4:0] S_FDONE = 5'd22;

	logic [4:0] state_q, state_d;
	logic render_q, render_d;

	always_comb begin
		state_d  = state_q;
		render_d = render_q;
		in_ready = 1'b0;
		cmd      = '{op: DP_NOP, div_step: 1'b0, adv_ph: ADV_NONE, adv_sel: ADV_I};
		case (state_q)
			S_CLR: begin
				cmd.op = DP_CLR;
				if (sts.clr_last) begin
					state_d = render_q ? S_JPRE : S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op) begin
						cmd.op = DP_RD;
						state_d = S_RDOUT;
					end else begin
						cmd.op = DP_START;
						render_d = 1'b1;
						state_d = S_CLR;
					end
				end
			end
			S_RDOUT: begin
				if (sts.out_free) begin
					cmd.op = DP_OUT_RD;
					state_d = S_IDLE;
				end
			end
			S_JPRE: begin
				cmd.op = DP_JPRE;
				state_d = S_P1;
			end
			S_P1: begin
				cmd.op = DP_P1;
				state_d = S_P2;
			end
			S_P2: begin
				cmd.op = DP_P2;
				state_d = S_P3;
			end
			S_P3: begin
				cmd.op = DP_P3;
				state_d = S_P4;
			end
			S_P4: begin
				cmd.op = DP_P4;
				state_d = S_A1;
			end
			// The ring rotation overlaps the first division steps.
			S_A1: begin
				cmd.div_step = 1'b1;
				cmd.adv_ph = ADV_ROT;
				state_d = S_A2;
			end
			S_A2: begin
				cmd.div_step = 1'b1;
				cmd.adv_ph = ADV_NORM;
				state_d = S_A3;
			end
			S_A3: begin
				cmd.div_step = 1'b1;
				cmd.adv_ph = ADV_SCALE;
				state_d = S_DIVW;
			end
			S_DIVW: begin
				if (sts.div_done) begin
					cmd.op = DP_ADDR;
					state_d = S_WR;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_WR: begin
				cmd.op = DP_WR;
				state_d = sts.i_last ? S_JA1 : S_P1;
			end
			S_JA1: begin
				cmd.adv_ph = ADV_ROT;
				cmd.adv_sel = ADV_J;
				state_d = S_JA2;
			end
			S_JA2: begin
				cmd.adv_ph = ADV_NORM;
				cmd.adv_sel = ADV_J;
				state_d = S_JA3;
			end
			S_JA3: begin
				cmd.adv_ph = ADV_SCALE;
				cmd.adv_sel = ADV_J;
				state_d = sts.j_last ? S_FA1 : S_JPRE;
			end
			S_FA1: begin
				cmd.adv_ph = ADV_ROT;
				cmd.adv_sel = ADV_A;
				state_d = S_FA2;
			end
			S_FA2: begin
				cmd.adv_ph = ADV_NORM;
				cmd.adv_sel = ADV_A;
				state_d = S_FA3;
			end
			S_FA3: begin
				cmd.adv_ph = ADV_SCALE;
				cmd.adv_sel = ADV_A;
				state_d = S_FB1;
			end
			S_FB1: begin
				cmd.adv_ph = ADV_ROT;
				cmd.adv_sel = ADV_B;
				state_d = S_FB2;
			end
			S_FB2: begin
				cmd.adv_ph = ADV_NORM;
				cmd.adv_sel = ADV_B;
				state_d = S_FB3;
			end
			S_FB3: begin
				cmd.adv_ph = ADV_SCALE;
				cmd.adv_sel = ADV_B;
				state_d = S_FDONE;
			end
			S_FDONE: begin
				if (sts.out_free) begin
					cmd.op = DP_OUT_FRM;
					render_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			render_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			render_q <= render_d;
		end
	end

endmodule

[src/tzr_datapath.sv]
module tzr_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tzr_pkg::dp_cmd_t           cmd,
	output tzr_pkg::dp_sts_t           sts,
	input  logic [tzr_pkg::ADDR_W-1:0] cell_index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [6:0]                 out_char,
	output logic                       out_done
);
	import tzr_pkg::*;

	logic [6:0]        char_mem [CELLS];
	logic signed [7:0] depth_mem [CELLS];

	logic signed [15:0] ci_q, si_q, cj_q, sj_q;
	logic signed [11:0] ca_q, sa_q, cb_q, sb_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [I_W-1:0]     i_q;
	logic [J_W-1:0]     j_q;

	logic signed [16:0] x0_q;
	logic signed [15:0] x2_q, x5_q, cjsb_q;
	logic signed [15:0] x1_q, x3_q, x7_q, x4_q, t_q;
	logic signed [31:0] cterm_q, x6_q, ax7_q, numx_q, numy_q;
	logic signed [35:0] inner_q;
	logic [3:0]         n_q;
	logic signed [7:0]  dz_q, dep_rd_q;
	logic               zero_q, ok_q;
	logic [ADDR_W-1:0]  o_q;
	logic [6:0]         char_rd_q;
	logic               oor_q;
	logic               out_valid_q, out_done_q;
	logic [6:0]         out_char_q;

	// Products, sized to their full width
	logic signed [27:0] p_x2, p_x5, p_sax3, p_cax3, p_cax7, p_sax7, p_cbx1, p_sbx4, p_cbx4, p_sbx1;
	logic signed [31:0] p_cjsb, p_x7;
	logic signed [32:0] p_x1, p_x3;
	logic signed [39:0] p_ct;
	logic signed [28:0] p_cbs, neg_sax7;
	logic signed [16:0] tx2;

	logic signed [39:0] nx, ny;
	logic signed [25:0] nsh;
	logic signed [19:0] n_raw;

	logic [7:0] qx, qy;
	logic negx, negy, ovfx, ovfy, donex, doney;
	logic signed [9:0] sx, sy, px, py;
	logic [ADDR_W-1:0] o;
	logic ok;

	logic signed [15:0] adv_c, adv_s, adv_c_new, adv_s_new;
	logic draw, we;
	logic [ADDR_W-1:0] wa;
	logic [ADDR_W-1:0] rd_addr;

	// Per tube step
	assign p_x2   = 28'(ca_q) * 28'(sj_q);
	assign p_x5   = 28'(sa_q) * 28'(sj_q);
	assign p_cjsb = 32'(cj_q) * 32'(sb_q);
	// Point stage 1
	assign p_x1 = 33'(ci_q) * 33'(x0_q);
	assign p_x3 = 33'(si_q) * 33'(x0_q);
	assign p_x7 = 32'(cj_q) * 32'(si_q);
	assign p_ct = 40'(ci_q) * 40'(cjsb_q);
	// Point stage 2
	assign p_sax3 = 28'(sa_q) * 28'(x3_q);
	assign p_cax3 = 28'(ca_q) * 28'(x3_q);
	assign p_cax7 = 28'(ca_q) * 28'(x7_q);
	assign p_sax7 = 28'(sa_q) * 28'(x7_q);
	assign neg_sax7 = -29'(p_sax7);
	// Point stage 3
	assign p_cbx1 = 28'(cb_q) * 28'(x1_q);
	assign p_sbx4 = 28'(sb_q) * 28'(x4_q);
	assign p_cbx4 = 28'(cb_q) * 28'(x4_q);
	assign p_sbx1 = 28'(sb_q) * 28'(x1_q);
	assign tx2    = 17'(t_q) + 17'(x2_q);
	assign p_cbs  = 29'(cb_q) * 29'(tx2);
	// Point stage 4
	assign nx    = (40'(numx_q) <<< 5) - (40'(numx_q) <<< 1);
	assign ny    = (40'(numy_q) <<< 4) - 40'(numy_q);
	assign nsh   = 26'(inner_q >>> 10) - 26'(x5_q);
	assign n_raw = 20'(nsh >>> 7);

	tzr_div u_div_x (
		.clk(clk), .arst_n(arst_n), .load(cmd.op == DP_P4), .step(cmd.div_step),
		.num(nx), .den(x6_q), .q(qx), .neg(negx), .ovf(ovfx), .done(donex)
	);

	tzr_div u_div_y (
		.clk(clk), .arst_n(arst_n), .load(cmd.op == DP_P4), .step(cmd.div_step),
		.num(ny), .den(x6_q), .q(qy), .neg(negy), .ovf(ovfy), .done(doney)
	);

	assign sx = negx ? -10'(qx) : 10'(qx);
	assign sy = negy ? -10'(qy) : 10'(qy);
	assign px = 10'sd40 + sx;
	assign py = 10'sd11 + sy;
	assign ok = !zero_q && !ovfx && !ovfy && (px > 10'sd0) && (px < 10'sd80)
		&& (py > 10'sd0) && (py < 10'sd22);
	assign o = 11'(px[6:0]) + 11'({py[4:0], 6'b0}) + 11'({py[4:0], 4'b0});

	always_comb begin
		case (cmd.adv_sel)
			ADV_I: begin
				adv_c = ci_q;
				adv_s = si_q;
			end
			ADV_J: begin
				adv_c = cj_q;
				adv_s = sj_q;
			end
			ADV_A: begin
				adv_c = 16'(ca_q);
				adv_s = 16'(sa_q);
			end
			default: begin
				adv_c = 16'(cb_q);
				adv_s = 16'(sb_q);
			end
		endcase
	end

	tzr_advance u_adv (
		.clk(clk), .ph(cmd.adv_ph), .sel(cmd.adv_sel),
		.c_in(adv_c), .s_in(adv_s), .c_out(adv_c_new), .s_out(adv_s_new)
	);

	// Point arithmetic
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_JPRE: begin
				x0_q   <= 17'(cj_q) + 17'sd2048;
				x2_q   <= 16'(p_x2 >>> 10);
				x5_q   <= 16'(p_x5 >>> 10);
				cjsb_q <= 16'(p_cjsb >>> 10);
			end
			DP_P1: begin
				x1_q    <= 16'(p_x1 >>> 10);
				x3_q    <= 16'(p_x3 >>> 10);
				x7_q    <= 16'(p_x7 >>> 10);
				cterm_q <= 32'(p_ct);
			end
			DP_P2: begin
				x4_q  <= x2_q - 16'(p_sax3 >>> 10);
				x6_q  <= VIEW_DIST + (32'(x5_q) <<< 10) + 32'(p_cax3);
				ax7_q <= 32'(p_cax7);
				t_q   <= 16'(neg_sax7 >>> 10);
			end
			DP_P3: begin
				numx_q  <= 32'(p_cbx1) - 32'(p_sbx4);
				numy_q  <= 32'(p_cbx4) + 32'(p_sbx1);
				inner_q <= -36'(ax7_q) - 36'(p_cbs) - 36'(cterm_q);
			end
			DP_P4: begin
				zero_q <= x6_q == 32'sd0;
				dz_q   <= 8'((x6_q - VIEW_DIST) >>> 15);
				if (n_raw < 20'sd0) begin
					n_q <= 4'd0;
				end else if (n_raw > 20'sd11) begin
					n_q <= 4'd11;
				end else begin
					n_q <= n_raw[3:0];
				end
			end
			DP_ADDR: begin
				ok_q <= ok;
				o_q  <= ok ? o : '0;
			end
			default: begin
			end
		endcase
	end

	// Character and depth stores
	assign draw = (cmd.op == DP_WR) && ok_q && (dz_q < dep_rd_q);
	assign we = (cmd.op == DP_CLR) || draw;
	assign wa = (cmd.op == DP_CLR) ? clr_q : o_q;
	assign rd_addr = (cell_index < ADDR_W'(CELLS)) ? cell_index : '0;

	always_ff @(posedge clk) begin
		if (we) begin
			char_mem[wa]  <= (cmd.op == DP_CLR) ? SPACE_CHAR : shade_char(n_q);
			depth_mem[wa] <= (cmd.op == DP_CLR) ? FAR_DEPTH : dz_q;
		end
		if (cmd.op == DP_ADDR) begin
			dep_rd_q <= depth_mem[ok ? o : '0];
		end
		if (cmd.op == DP_RD) begin
			char_rd_q <= char_mem[rd_addr];
			oor_q     <= cell_index >= ADDR_W'(CELLS);
		end
		if (cmd.op == DP_OUT_RD) begin
			out_char_q <= oor_q ? SPACE_CHAR : char_rd_q;
			out_done_q <= 1'b0;
		end else if (cmd.op == DP_OUT_FRM) begin
			out_char_q <= SPACE_CHAR;
			out_done_q <= 1'b1;
		end
	end

	// Loop state, rotation state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			i_q   <= '0;
			j_q   <= '0;
			ci_q  <= 16'sd1024;
			si_q  <= 16'sd0;
			cj_q  <= 16'sd1024;
			sj_q  <= 16'sd0;
			ca_q  <= 12'sd0;
			sa_q  <= 12'sd1024;
			cb_q  <= 12'sd0;
			sb_q  <= 12'sd1024;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == DP_START) begin
				clr_q <= '0;
				j_q   <= '0;
				cj_q  <= 16'sd1024;
				sj_q  <= 16'sd0;
			end
			if (cmd.op == DP_CLR) begin
				clr_q <= sts.clr_last ? '0 : clr_q + 1'b1;
			end
			if (cmd.op == DP_JPRE) begin
				i_q  <= '0;
				ci_q <= 16'sd1024;
				si_q <= 16'sd0;
			end
			if (cmd.op == DP_WR) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.adv_ph == ADV_SCALE) begin
				case (cmd.adv_sel)
					ADV_I: begin
						ci_q <= adv_c_new;
						si_q <= adv_s_new;
					end
					ADV_J: begin
						cj_q <= adv_c_new;
						sj_q <= adv_s_new;
						j_q  <= j_q + 1'b1;
					end
					ADV_A: begin
						ca_q <= 12'(adv_c_new);
						sa_q <= 12'(adv_s_new);
					end
					default: begin
						cb_q <= 12'(adv_c_new);
						sb_q <= 12'(adv_s_new);
					end
				endcase
			end
			if ((cmd.op == DP_OUT_RD) || (cmd.op == DP_OUT_FRM)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_last = clr_q == ADDR_W'(CELLS - 1);
	assign sts.div_done = donex && doney;
	assign sts.i_last   = i_q == I_W'(RING_STEPS - 1);
	assign sts.j_last   = j_q == J_W'(TUBE_STEPS - 1);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_done  = out_done_q;

endmodule

[src/torus_zbuffer_renderer_unit.sv]
// Read request: the cell is read into a register on acceptance, then moved to
// the output register once the output is free. Render request: all 1760 cells
// of the stores are cleared, then 90 x 324 surface points are walked one at a time,
// each using the two iterative dividers and the shared rotation unit, then the angles
// are advanced. One request is worked on at a time; a waiting result does not block
// acceptance. After reset all 1760 cells are cleared; no request is taken meanwhile.
`include "assert_macros.svh"

module torus_zbuffer_renderer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [tzr_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [10:0] cell_index
	input  logic                           s_axis_tuser,  // [0] opcode
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [tzr_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [6:0] cell_char
	output logic                           m_axis_tuser   // [0] frame_done
);
	import tzr_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [6:0] out_char;

	tzr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_op(s_axis_tuser),
		.in_ready(s_axis_tready), .sts(sts), .cmd(cmd)
	);

	tzr_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cell_index(s_axis_tdata[ADDR_W-1:0]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_char(out_char), .out_done(m_axis_tuser)
	);

	assign m_axis_tdata = {1'b0, out_char};

	`ASSERT_ALWAYS(a_one_request, clk, arst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
	`ASSERT_NEVER(a_div_overrun, clk, arst_n, cmd.div_step && sts.div_done)
	`ASSERT_ALWAYS(a_out_free, clk, arst_n, (cmd.op == DP_OUT_RD || cmd.op == DP_OUT_FRM) |-> sts.out_free)

endmodule

[test/torus_zbuffer_renderer_unit_test.sv]
`timescale 1ns / 1ps

module torus_zbuffer_renderer_unit_test;
	import tzr_pkg::*;

	localparam int RANDOM_READS = 81;
	localparam longint CYCLE_LIMIT = 5000000;

	typedef struct {
		logic [6:0] cell_char;
		logic       frame_done;
	} cell_result_t;

	typedef struct {
		logic        op;
		logic [10:0] idx;
		bit          known;
		logic [6:0]  cell_char;
		logic        frame_done;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;  // [10:0] cell_index
	logic s_axis_tuser;                  // [0] opcode
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata; // [6:0] cell_char
	logic m_axis_tuser;                  // [0] frame_done

	// Predicted frame state.
	logic [6:0] frame_chars [0:CELLS-1];
	logic signed [7:0] frame_depth [0:CELLS-1];
	longint ang_sa, ang_ca, ang_sb, ang_cb;

	cell_result_t pending_results [$];
	stim_row_t directed_rows [$];
	bit known_next;
	cell_result_t known_value;
	bit calm;
	bit hold_req;
	int hold_left;
	int mismatches;
	int renders_seen;
	int reads_seen;
	longint cycles;

	torus_zbuffer_renderer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void rotate_pair(input longint mul, input int sh,
			ref longint c, ref longint s);
		longint t;
		longint k;
		t = c;
		c = c - ((mul * s) >>> sh);
		s = s + ((mul * t) >>> sh);
		k = (longint'(NORM_CONST) - c * c - s * s) >>> 11;
		c = (c * k) >>> 10;
		s = (s * k) >>> 10;
	endfunction

	function automatic longint wrap_angle(input longint v);
		logic [11:0] b;
		b = v[11:0];
		return longint'($signed(b));
	endfunction

	function automatic logic [6:0] shade_of(input longint n);
		logic [6:0] lut [0:11];
		lut = '{7'd46, 7'd44, 7'd45, 7'd126, 7'd58, 7'd59,
			7'd61, 7'd33, 7'd42, 7'd35, 7'd36, 7'd64};
		if (n < 0)
			n = 0;
		if (n > 11)
			n = 11;
		return lut[n];
	endfunction

	task automatic draw_frame();
		longint sj, cj, si, ci;
		longint x0, x1, x2, x3, x4, x5, x6, x7, px, py, inner, n, o;
		logic [7:0] db;
		logic signed [7:0] dz;
		for (int c = 0; c < CELLS; c++) begin
			frame_chars[c] = 7'd32;
			frame_depth[c] = 8'sd127;
		end
		sj = 0;
		cj = 1024;
		for (int j = 0; j < 90; j++) begin
			si = 0;
			ci = 1024;
			for (int i = 0; i < 324; i++) begin
				x0 = cj + 2048;
				x1 = (ci * x0) >>> 10;
				x2 = (ang_ca * sj) >>> 10;
				x3 = (si * x0) >>> 10;
				x4 = x2 - ((ang_sa * x3) >>> 10);
				x5 = (ang_sa * sj) >>> 10;
				x6 = 64'sd5242880 + 1024 * x5 + ang_ca * x3;
				x7 = (cj * si) >>> 10;
				if (x6 != 0) begin
					px = 40 + 30 * (ang_cb * x1 - ang_sb * x4) / x6;
					py = 11 + 15 * (ang_cb * x4 + ang_sb * x1) / x6;
					inner = -ang_ca * x7 - ang_cb * (((-ang_sa * x7) >>> 10) + x2)
						- ci * ((cj * ang_sb) >>> 10);
					n = ((inner >>> 10) - x5) >>> 7;
					db = 8'((x6 - 64'sd5242880) >>> 15);
					dz = $signed(db);
					if (py > 0 && py < 22 && px > 0 && px < 80) begin
						o = px + 80 * py;
						if (o < CELLS && dz < frame_depth[o]) begin
							frame_depth[o] = dz;
							frame_chars[o] = shade_of(n);
						end
					end
				end
				rotate_pair(5, 8, ci, si);
			end
			rotate_pair(9, 7, cj, sj);
		end
		rotate_pair(5, 7, ang_ca, ang_sa);
		rotate_pair(5, 8, ang_cb, ang_sb);
		ang_ca = wrap_angle(ang_ca);
		ang_sa = wrap_angle(ang_sa);
		ang_cb = wrap_angle(ang_cb);
		ang_sb = wrap_angle(ang_sb);
	endtask

	task automatic predict_request(input logic op, input logic [10:0] idx,
			output cell_result_t r);
		if (op == 1'b0) begin
			draw_frame();
			r.cell_char = 7'd32;
			r.frame_done = 1'b1;
		end else begin
			r.cell_char = (idx < CELLS) ? frame_chars[idx] : 7'd32;
			r.frame_done = 1'b0;
		end
	endtask

	// Scoreboard: results are compared before new requests are predicted, since
	// a result can never belong to a request taken at the same edge.
	always @(posedge clk) begin
		cell_result_t want;
		cell_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.cell_char = m_axis_tdata[6:0];
			got.frame_done = m_axis_tuser;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result char=%0d done=%0b", got.cell_char,
						got.frame_done);
			end else begin
				want = pending_results.pop_front();
				if (got.frame_done) renders_seen++; else reads_seen++;
				if (got.cell_char !== want.cell_char || got.frame_done !== want.frame_done)
						begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected char=%0d done=%0b, got char=%0d done=%0b",
							want.cell_char, want.frame_done, got.cell_char, got.frame_done);
				end
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			predict_request(s_axis_tuser, s_axis_tdata[10:0], want);
			if (known_next)
				want = known_value;
			pending_results.push_back(want);
		end
	end

	// Receiver: random back-pressure plus one long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left <= 300;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= 21);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic add_row(input logic op, input logic [10:0] idx, input bit known,
			input logic [6:0] ch, input logic done);
		stim_row_t r;
		r.op = op;
		r.idx = idx;
		r.known = known;
		r.cell_char = ch;
		r.frame_done = done;
		directed_rows.push_back(r);
	endtask

	task automatic send_request(input logic op, input logic [10:0] idx, input bit known,
			input logic [6:0] ch, input logic done);
		int gap;
		gap = calm ? 0 : (($urandom_range(99) < 21) ? $urandom_range(1, 6) : 0);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {5'd0, idx};
		known_next <= known;
		known_value.cell_char <= ch;
		known_value.frame_done <= done;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	initial begin
		int settle;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		known_next = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		mismatches = 0;
		renders_seen = 0;
		reads_seen = 0;
		cycles = 0;
		for (int c = 0; c < CELLS; c++) begin
			frame_chars[c] = 7'd32;
			frame_depth[c] = 8'sd127;
		end
		ang_sa = 1024;
		ang_ca = 0;
		ang_sb = 1024;
		ang_cb = 0;

		// Known answers: an empty frame after reset, out-of-range reads and
		// render acknowledgements.
		add_row(1'b1, 11'd0, 1, 7'd32, 1'b0);
		add_row(1'b1, 11'd1759, 1, 7'd32, 1'b0);
		add_row(1'b1, 11'd1760, 1, 7'd32, 1'b0);
		add_row(1'b1, 11'd2047, 1, 7'd32, 1'b0);
		add_row(1'b1, 11'd925, 1, 7'd32, 1'b0);
		add_row(1'b0, 11'd2047, 1, 7'd32, 1'b1);
		add_row(1'b1, 11'd0, 1, 7'd32, 1'b0);
		add_row(1'b1, 11'd80, 1, 7'd32, 1'b0);
		add_row(1'b1, 11'd1720, 0, 7'd0, 1'b0);
		add_row(1'b1, 11'd920, 0, 7'd0, 1'b0);
		add_row(1'b1, 11'd900, 0, 7'd0, 1'b0);
		add_row(1'b1, 11'd1010, 0, 7'd0, 1'b0);
		add_row(1'b1, 11'd2000, 1, 7'd32, 1'b0);
		add_row(1'b0, 11'd0, 1, 7'd32, 1'b1);
		add_row(1'b1, 11'd920, 0, 7'd0, 1'b0);
		add_row(1'b1, 11'd1000, 0, 7'd0, 1'b0);
		add_row(1'b1, 11'd1759, 0, 7'd0, 1'b0);
		add_row(1'b1, 11'd1365, 0, 7'd0, 1'b0);
		add_row(1'b1, 11'd682, 0, 7'd0, 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k])
			send_request(directed_rows[k].op, directed_rows[k].idx, directed_rows[k].known,
				directed_rows[k].cell_char, directed_rows[k].frame_done);

		for (int k = 0; k < RANDOM_READS; k++) begin
			calm <= (k >= 60 && k < 80);
			if (k == 30)
				hold_req = 1'b1;
			// Mostly indices inside the frame, with the full index range
			// now and then.
			send_request(1'b1, ($urandom_range(3) == 0) ? 11'($urandom_range(2047))
				: 11'($urandom_range(1759)), 0, 7'd0, 1'b0);
		end
		s_axis_tvalid <= 1'b0;
		known_next <= 1'b0;
		calm <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		settle = 0;
		while (settle < 20) begin
			@(posedge clk);
			settle++;
		end

		$display("Checked %0d frame renders and %0d cell reads, including out-of-range",
			renders_seen, reads_seen);
		$display("indices and a long output hold-off.");
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
